FILE: design/rsk_pkg.sv
// package for the small rsa key generation and modular exponentiation block
`default_nettype none
package rsk_pkg;
	localparam int PRIME_BITS_DEF = 16;
	localparam int FIRST_PRIME_RST = 61;
	localparam int SECOND_PRIME_RST = 53;
	localparam int WORD_BITS = 64;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SETUP,
		ST_GCD_INIT,
		ST_GCD_DIV,
		ST_GCD_CHECK,
		ST_INV_INIT,
		ST_INV_DIV,
		ST_INV_MUL,
		ST_INV_NEXT,
		ST_KEY_DONE,
		ST_MSG_RED,
		ST_EXP_INIT,
		ST_EXP_BIT,
		ST_EXP_MUL,
		ST_EXP_SQR,
		ST_EXP_NEXT,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SETUP,
		OP_GCD_INIT,
		OP_GCD_STEP,
		OP_E_INC,
		OP_INV_INIT,
		OP_INV_STEP,
		OP_INV_T,
		OP_KEY_CHECK,
		OP_MSG_RED,
		OP_EXP1_INIT,
		OP_EXP2_INIT,
		OP_EXP_MUL,
		OP_EXP_SQR,
		OP_EXP_SHIFT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic div_start;
		logic mul_start;
		logic mul_sel;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic mul_busy;
		logic gcd_zero;
		logic gcd_one;
		logic e_below_phi;
		logic phi_one;
		logic phi_ge2;
		logic key_ok;
		logic exp_zero;
		logic exp_bit;
		logic second_pass;
		logic mod_le1;
	} stat_t;
endpackage
`default_nettype wire

FILE: design/rsa_small_keygen_and_modexp.sv
// top level of the small rsa key generation and modular exponentiation block
// channel | signals                                   | beat
// input   | start, busy, message                      | start && !busy
// output  | done, public_exponent .. key_valid        | done, one cycle
// config  | psel penable pwrite paddr pwdata prdata   | psel && penable && pwrite
// per beat: a key search of gcd and inverse steps, each a pass of the bit-serial
// divider (an inverse step adds one shift-add product), then a message reduction
// on the divider and two exponentiations of up to 32 rounds, each round one or two
// modular products
// busy goes high once a beat is accepted and stays high through the done cycle
// reset clears control state and restores the primes; results cannot be stalled
`default_nettype none
module rsa_small_keygen_and_modexp #(
	parameter int PRIME_BITS = rsk_pkg::PRIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [31:0]           message,
	output logic                       done,
	output logic [31:0]                public_exponent,
	output logic [31:0]                private_exponent,
	output logic [31:0]                ciphertext,
	output logic [31:0]                recovered,
	output logic                       key_valid,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import rsk_pkg::*;

	logic [PRIME_BITS-1:0] p_q, q_q;
	cmd_t cmd;
	stat_t stat;
	logic [31:0] msg_red;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= PRIME_BITS'(FIRST_PRIME_RST);
			q_q <= PRIME_BITS'(SECOND_PRIME_RST);
		end else if (psel && penable && pwrite) begin
			if (paddr == 3'd0) p_q <= pwdata[PRIME_BITS-1:0];
			else if (paddr == 3'd4) q_q <= pwdata[PRIME_BITS-1:0];
		end
	end

	always_comb begin
		unique case (paddr)
			3'd0: prdata = 32'(p_q);
			3'd4: prdata = 32'(q_q);
			default: prdata = '0;
		endcase
	end

	assign msg_red = message;

	rsk_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .stat(stat)
	);

	rsk_dp #(.PRIME_BITS(PRIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .p(p_q), .q(q_q), .message(msg_red),
		.cmd(cmd), .stat(stat),
		.public_exponent(public_exponent), .private_exponent(private_exponent),
		.ciphertext(ciphertext), .recovered(recovered), .key_valid(key_valid)
	);
endmodule
`default_nettype wire

FILE: design/rsk_ctrl.sv
// controller state machine for key search and exponentiation
`default_nettype none
module rsk_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output rsk_pkg::cmd_t      cmd,
	input  rsk_pkg::stat_t     stat
);
	import rsk_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_GCD_INIT;
			ST_GCD_INIT: state_d = stat.gcd_zero ? ST_GCD_CHECK : ST_GCD_DIV;
			ST_GCD_DIV: if (!stat.div_busy) state_d = ST_GCD_INIT;
			ST_GCD_CHECK: begin
				if (stat.gcd_one || !stat.e_below_phi) state_d = ST_INV_INIT;
				else state_d = ST_GCD_INIT;
			end
			ST_INV_INIT: begin
				if (stat.phi_one || !stat.phi_ge2 || !stat.gcd_one) state_d = ST_KEY_DONE;
				else state_d = stat.gcd_zero ? ST_KEY_DONE : ST_INV_DIV;
			end
			ST_INV_DIV: if (!stat.div_busy) state_d = ST_INV_MUL;
			ST_INV_MUL: if (!stat.mul_busy) state_d = ST_INV_NEXT;
			ST_INV_NEXT: state_d = stat.gcd_zero ? ST_KEY_DONE : ST_INV_DIV;
			ST_KEY_DONE: state_d = stat.key_ok ? ST_MSG_RED : ST_DONE;
			ST_MSG_RED: if (!stat.div_busy) state_d = ST_EXP_INIT;
			ST_EXP_INIT: state_d = ST_EXP_BIT;
			ST_EXP_BIT: begin
				if (stat.exp_zero || stat.mod_le1) begin
					state_d = stat.second_pass ? ST_DONE : ST_EXP_INIT;
				end else begin
					state_d = stat.exp_bit ? ST_EXP_MUL : ST_EXP_SQR;
				end
			end
			ST_EXP_MUL: if (!stat.mul_busy) state_d = ST_EXP_SQR;
			ST_EXP_SQR: if (!stat.mul_busy) state_d = ST_EXP_NEXT;
			ST_EXP_NEXT: state_d = ST_EXP_BIT;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
		unique case (state_q)
			ST_IDLE: cmd.op = start ? OP_SETUP : OP_NONE;
			ST_SETUP: cmd.op = OP_GCD_INIT;
			ST_GCD_INIT: begin
				cmd.op = OP_NONE;
				cmd.div_start = !stat.gcd_zero;
			end
			ST_GCD_DIV: begin
				if (!stat.div_busy) begin
					cmd.op = OP_GCD_STEP;
				end
			end
			ST_GCD_CHECK: begin
				if (stat.gcd_one || !stat.e_below_phi) cmd.op = OP_INV_INIT;
				else cmd.op = OP_E_INC;
			end
			ST_INV_INIT: cmd.div_start = stat.phi_ge2 && !stat.phi_one && stat.gcd_one
				&& !stat.gcd_zero;
			ST_INV_DIV: begin
				if (!stat.div_busy) begin
					cmd.op = OP_INV_STEP;
					cmd.mul_start = 1'b1;
				end
			end
			ST_INV_MUL: if (!stat.mul_busy) cmd.op = OP_INV_T;
			ST_INV_NEXT: cmd.div_start = !stat.gcd_zero;
			ST_KEY_DONE: begin
				if (stat.key_ok) begin
					cmd.op = OP_MSG_RED;
					cmd.div_start = 1'b1;
				end else begin
					cmd.op = OP_KEY_CHECK;
				end
			end
			ST_MSG_RED: if (!stat.div_busy) cmd.op = OP_EXP1_INIT;
			ST_EXP_INIT: cmd.op = OP_NONE;
			ST_EXP_BIT: begin
				if (stat.exp_zero || stat.mod_le1) begin
					cmd.op = stat.second_pass ? OP_NONE : OP_EXP2_INIT;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel = !stat.exp_bit;
				end
			end
			ST_EXP_MUL: begin
				if (!stat.mul_busy) begin
					cmd.op = OP_EXP_MUL;
					cmd.mul_start = 1'b1;
					cmd.mul_sel = 1'b1;
				end
			end
			ST_EXP_SQR: if (!stat.mul_busy) cmd.op = OP_EXP_SQR;
			ST_EXP_NEXT: cmd.op = OP_EXP_SHIFT;
			ST_DONE: cmd.op = OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end
endmodule
`default_nettype wire

FILE: design/rsk_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module rsk_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire logic [rsk_pkg::WORD_BITS-1:0] num,
	input  wire logic [rsk_pkg::WORD_BITS-1:0] den,
	output logic                               busy,
	output logic [rsk_pkg::WORD_BITS-1:0]      quo,
	output logic [rsk_pkg::WORD_BITS-1:0]      rem
);
	import rsk_pkg::*;
	localparam int CW = $clog2(WORD_BITS + 1);

	logic [CW-1:0] cnt_q;
	logic [WORD_BITS-1:0] d_q;
	logic [WORD_BITS:0] trial;

	assign busy = (cnt_q != '0);
	assign trial = {rem, quo[WORD_BITS-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CW'(WORD_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			d_q <= den;
			quo <= num;
			rem <= '0;
		end else if (busy) begin
			if (!trial[WORD_BITS]) begin
				rem <= trial[WORD_BITS-1:0];
				quo <= {quo[WORD_BITS-2:0], 1'b1};
			end else begin
				rem <= {rem[WORD_BITS-2:0], quo[WORD_BITS-1]};
				quo <= {quo[WORD_BITS-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/rsk_mulmod.sv
// shift and add modular multiplier, one multiplier bit per cycle
`default_nettype none
module rsk_mulmod (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire logic [rsk_pkg::WORD_BITS-1:0] a,
	input  wire logic [rsk_pkg::WORD_BITS-1:0] b,
	input  wire logic [rsk_pkg::WORD_BITS-1:0] m,
	output logic                               busy,
	output logic [rsk_pkg::WORD_BITS-1:0]      prod
);
	import rsk_pkg::*;

	logic [WORD_BITS-1:0] a_q, b_q, m_q;
	logic run_q;
	logic [WORD_BITS:0] sum_r, dbl_a;
	logic [WORD_BITS-1:0] r_n, a_n;

	assign busy = run_q;
	assign sum_r = {1'b0, prod} + {1'b0, a_q};
	assign dbl_a = {a_q, 1'b0};
	assign r_n = (sum_r >= {1'b0, m_q}) ? WORD_BITS'(sum_r - {1'b0, m_q})
		: sum_r[WORD_BITS-1:0];
	assign a_n = (dbl_a >= {1'b0, m_q}) ? WORD_BITS'(dbl_a - {1'b0, m_q})
		: dbl_a[WORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) run_q <= 1'b0;
		else if (go) run_q <= 1'b1;
		else if (b_q == '0) run_q <= 1'b0;
	end

	// operands arrive already reduced below m
	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			prod <= '0;
		end else if (run_q && b_q != '0) begin
			if (b_q[0]) prod <= r_n;
			a_q <= a_n;
			b_q <= b_q >> 1;
		end
	end
endmodule
`default_nettype wire

FILE: design/rsk_dp.sv
// datapath: key registers, search state and exponentiation registers
`default_nettype none
module rsk_dp #(
	parameter int PRIME_BITS = rsk_pkg::PRIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [PRIME_BITS-1:0] p,
	input  wire logic [PRIME_BITS-1:0] q,
	input  wire logic [31:0]           message,
	input  rsk_pkg::cmd_t              cmd,
	output rsk_pkg::stat_t             stat,
	output logic [31:0]                public_exponent,
	output logic [31:0]                private_exponent,
	output logic [31:0]                ciphertext,
	output logic [31:0]                recovered,
	output logic                       key_valid
);
	import rsk_pkg::*;
	localparam int W = WORD_BITS;

	logic [W-1:0] n_q, phi_q, e_q, d_q, msg_q;
	logic [W-1:0] ga_q, gb_q;
	logic [W-1:0] r0_q, r1_q, t0_q, t1_q, qt_q;
	logic [W-1:0] res_q, base_q, ex_q;
	logic pass2_q, valid_q, g1_q;

	logic div_busy, mul_busy;
	logic [W-1:0] quo, rem, prod;
	logic [W-1:0] div_num, div_den, mul_a, mul_b, mul_m;
	logic in_inv;

	logic [PRIME_BITS-1:0] pm1, qm1;
	logic [2*PRIME_BITS-1:0] n_w, phi_w;
	assign pm1 = (p == '0) ? '0 : p - 1'b1;
	assign qm1 = (q == '0) ? '0 : q - 1'b1;
	assign n_w = p * q;
	assign phi_w = pm1 * qm1;

	// message reduction to below n uses the divider ahead of the first pass
	assign in_inv = (cmd.op == OP_INV_STEP) || (cmd.op == OP_INV_T) || !g1_q;
	assign div_num = (cmd.op == OP_MSG_RED) ? msg_q : (g1_q ? r0_q : ga_q);
	assign div_den = (cmd.op == OP_MSG_RED) ? n_q : (g1_q ? r1_q : gb_q);
	assign mul_a = in_inv ? qt_q : (cmd.mul_sel ? base_q : res_q);
	assign mul_b = in_inv ? t1_q : base_q;
	assign mul_m = in_inv ? phi_q : n_q;

	rsk_div u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_start),
		.num(div_num), .den(div_den), .busy(div_busy), .quo(quo), .rem(rem)
	);

	logic [W-1:0] mul_a_r, mul_b_r;
	assign mul_a_r = (cmd.op == OP_INV_STEP) ? quo : mul_a;
	assign mul_b_r = mul_b;

	rsk_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .go(cmd.mul_start),
		.a(mul_a_r), .b(mul_b_r), .m(mul_m), .busy(mul_busy), .prod(prod)
	);

	logic [W-1:0] tsub;
	assign tsub = (t0_q >= prod) ? t0_q - prod : t0_q + (phi_q - prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass2_q <= 1'b0;
			valid_q <= 1'b0;
			g1_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_SETUP: begin
					pass2_q <= 1'b0;
					g1_q <= 1'b0;
				end
				OP_INV_INIT: g1_q <= 1'b1;
				OP_EXP1_INIT: valid_q <= 1'b1;
				OP_KEY_CHECK: valid_q <= 1'b0;
				OP_EXP2_INIT: pass2_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SETUP: begin
				n_q <= W'(n_w);
				phi_q <= W'(phi_w);
				e_q <= W'(2);
				msg_q <= W'(message);
			end
			OP_GCD_INIT: begin
				ga_q <= e_q;
				gb_q <= phi_q;
			end
			OP_GCD_STEP: begin
				ga_q <= gb_q;
				gb_q <= rem;
			end
			OP_E_INC: begin
				e_q <= e_q + 1'b1;
				ga_q <= e_q + 1'b1;
				gb_q <= phi_q;
			end
			OP_INV_INIT: begin
				r0_q <= phi_q;
				r1_q <= e_q;
				t0_q <= '0;
				t1_q <= W'(1);
				d_q <= (phi_q == W'(1)) ? W'(2) : '0;
			end
			OP_INV_STEP: begin
				qt_q <= quo;
				r0_q <= r1_q;
				r1_q <= rem;
			end
			OP_INV_T: begin
				t0_q <= t1_q;
				t1_q <= tsub;
			end
			OP_EXP1_INIT: begin
				res_q <= W'(1);
				base_q <= rem;
				ex_q <= e_q;
				if (phi_q != W'(1)) d_q <= t0_q;
			end
			OP_EXP2_INIT: begin
				msg_q <= (n_q <= W'(1)) ? '0 : res_q;
				res_q <= W'(1);
				base_q <= (n_q <= W'(1)) ? '0 : res_q;
				ex_q <= d_q;
			end
			OP_EXP_MUL: res_q <= prod;
			OP_EXP_SQR: base_q <= prod;
			OP_EXP_SHIFT: ex_q <= ex_q >> 1;
			default: ;
		endcase
	end

	logic [W-1:0] dfin;
	assign dfin = (phi_q == W'(1)) ? W'(2) : t0_q;

	assign stat.div_busy = div_busy;
	assign stat.mul_busy = mul_busy;
	assign stat.gcd_zero = g1_q ? (r1_q == '0) : (gb_q == '0);
	assign stat.gcd_one = g1_q ? 1'b1 : (ga_q == W'(1));
	assign stat.e_below_phi = (e_q + 1'b1) < phi_q;
	assign stat.phi_one = (phi_q == W'(1));
	assign stat.phi_ge2 = (phi_q >= W'(2)) && g1_q;
	assign stat.key_ok = (phi_q == W'(1)) ? (n_q >= W'(2))
		: ((phi_q >= W'(2)) && (r0_q == W'(1)) && (dfin >= W'(2)) && (dfin <= n_q));
	assign stat.exp_zero = (ex_q == '0);
	assign stat.exp_bit = ex_q[0];
	assign stat.second_pass = pass2_q;
	assign stat.mod_le1 = (n_q <= W'(1));

	assign public_exponent = valid_q ? e_q[31:0] : '0;
	assign private_exponent = valid_q ? d_q[31:0] : '0;
	assign ciphertext = valid_q ? ((n_q <= W'(1)) ? 32'd0 : msg_q[31:0]) : '0;
	assign recovered = valid_q ? ((n_q <= W'(1)) ? 32'd0 : res_q[31:0]) : '0;
	assign key_valid = valid_q;
endmodule
`default_nettype wire

FILE: design/rsk_checker.sv
// port checker for the rsa block and its bind
`default_nettype none
module rsk_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic key_valid,
	input wire logic [31:0] public_exponent,
	input wire logic pready
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after start");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done twice");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !key_valid |-> public_exponent == 32'd0) else $error("bad no-key beat");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind rsa_small_keygen_and_modexp rsk_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.key_valid(key_valid), .public_exponent(public_exponent), .pready(pready)
);
`default_nettype wire

FILE: bench/rsa_small_keygen_and_modexp_tb.sv
// testbench for the small rsa key generation and modular exponentiation block
`timescale 1ns / 1ps
`default_nettype none
module rsa_small_keygen_and_modexp_tb;
	import rsk_pkg::*;

	localparam int REG_FIRST_PRIME = 0;
	localparam int REG_SECOND_PRIME = 1;
	localparam int PRIME_MASK = (1 << PRIME_BITS_DEF) - 1;

	typedef struct {
		logic [31:0] e;
		logic [31:0] d;
		logic [31:0] c;
		logic [31:0] r;
		logic        ok;
	} rsa_result_t;

	class rsa_scoreboard;
		longint unsigned prime_p = FIRST_PRIME_RST;
		longint unsigned prime_q = SECOND_PRIME_RST;
		rsa_result_t pending[$];
		bit failed = 0;

		function longint unsigned gcd(longint unsigned a, longint unsigned b);
			longint unsigned t;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			return a;
		endfunction

		function longint unsigned powmod(longint unsigned b, longint unsigned x,
				longint unsigned m);
			longint unsigned acc;
			if (m <= 1) return 0;
			acc = 1;
			b = b % m;
			while (x != 0) begin
				if (x[0]) acc = (acc * b) % m;
				b = (b * b) % m;
				x = x >> 1;
			end
			return acc;
		endfunction

		function longint unsigned invmod(longint unsigned e, longint unsigned m);
			longint r0, r1, t0, t1, qt, tmp;
			r0 = m; r1 = e % m; t0 = 0; t1 = 1;
			while (r1 != 0) begin
				qt = r0 / r1;
				tmp = r0 - qt * r1; r0 = r1; r1 = tmp;
				tmp = t0 - qt * t1; t0 = t1; t1 = tmp;
			end
			t0 = t0 % longint'(m);
			if (t0 < 0) t0 = t0 + m;
			return t0;
		endfunction

		function void set_reg(int idx, logic [31:0] val);
			if (idx == REG_FIRST_PRIME) prime_p = 64'(val & PRIME_MASK);
			else if (idx == REG_SECOND_PRIME) prime_q = 64'(val & PRIME_MASK);
		endfunction

		function void note(logic [31:0] msg);
			longint unsigned n, phi, e, d;
			bit ok;
			rsa_result_t x;
			n = prime_p * prime_q;
			phi = (prime_p >= 1 && prime_q >= 1) ? (prime_p - 1) * (prime_q - 1) : 0;
			e = 2; d = 0; ok = 0;
			while (e < phi && gcd(e, phi) != 1) e++;
			if (phi == 1) begin
				d = 2;
				ok = (n >= 2);
			end else if (phi >= 2 && gcd(e, phi) == 1) begin
				d = invmod(e, phi);
				ok = (d >= 2 && d <= n);
			end
			x = '{0, 0, 0, 0, 0};
			if (ok) begin
				x.e = e[31:0];
				x.d = d[31:0];
				x.c = 32'(powmod(msg, e, n));
				x.r = 32'(powmod(x.c, d, n));
				x.ok = 1;
			end
			pending.push_back(x);
		endfunction

		function void check(rsa_result_t got);
			rsa_result_t w;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				failed = 1;
				return;
			end
			w = pending.pop_front();
			if (got.e !== w.e) begin
				$error("public_exponent exp %0d got %0d", w.e, got.e); failed = 1;
			end
			if (got.d !== w.d) begin
				$error("private_exponent exp %0d got %0d", w.d, got.d); failed = 1;
			end
			if (got.c !== w.c) begin
				$error("ciphertext exp %0d got %0d", w.c, got.c); failed = 1;
			end
			if (got.r !== w.r) begin
				$error("recovered exp %0d got %0d", w.r, got.r); failed = 1;
			end
			if (got.ok !== w.ok) begin
				$error("key_valid exp %0d got %0d", w.ok, got.ok); failed = 1;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [31:0] message = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0;
	wire busy, done, key_valid, pready;
	wire [31:0] public_exponent, private_exponent, ciphertext, recovered, prdata;

	rsa_scoreboard sb = new();
	bit quiet = 0;

	rsa_small_keygen_and_modexp dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .message(message),
		.done(done), .public_exponent(public_exponent),
		.private_exponent(private_exponent), .ciphertext(ciphertext),
		.recovered(recovered), .key_valid(key_valid), .psel(psel),
		.penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check('{public_exponent, private_exponent, ciphertext, recovered,
				key_valid});
	end

	task automatic reg_write(int idx, logic [15:0] val);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= 3'(idx * 4);
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, {16'h0, val});
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic set_key(logic [15:0] p, logic [15:0] q);
		while (sb.pending.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		reg_write(REG_FIRST_PRIME, p);
		reg_write(REG_SECOND_PRIME, q);
	endtask

	function automatic logic [31:0] pick_msg();
		longint unsigned n;
		n = sb.prime_p * sb.prime_q;
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'hffff_ffff;
			2: return (n == 0) ? 0 : 32'(n - 1);
			3: return 32'(n);
			4: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic send(logic [31:0] msg);
		int gap;
		start <= 1;
		message <= msg;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note(msg);
		gap = 0;
		if (!quiet && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 17);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_burst(int count);
		repeat (count) send(pick_msg());
		start <= 0;
		@(posedge clk);
	endtask

	initial begin
		int small_primes[$] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
			47, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(0); send(1); send(32'hffff_ffff); send(3232); send(3233); send(3234);
		send(32'h8000_0000); send(42); send(2);
		start <= 0;
		@(posedge clk);
		set_key(2, 3);     send_burst(2);
		set_key(2, 2);     send_burst(3);
		set_key(0, 7);     send_burst(2);
		set_key(1, 1);     send_burst(2);
		set_key(3, 5);     send_burst(3);
		set_key(65521, 65519); send_burst(2);
		set_key(65535, 65535); send_burst(2);

		for (int ph = 0; ph < 8; ph++) begin
			set_key(16'(small_primes[$urandom_range(0, small_primes.size() - 1)]),
				16'(small_primes[$urandom_range(0, small_primes.size() - 1)]));
			send_burst(13);
		end
		set_key(16'($urandom_range(2, 65535)), 16'($urandom_range(2, 300)));
		send_burst(4);
		set_key(65521, 251);
		quiet = 1;
		send_burst(12);

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (!sb.failed && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
